FILE: rtl/core/helap_pkg.sv
package helap_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // unsigned coefficient registers
    localparam int COEF_WIDTH    = 31;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIFFUSION_COEF = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TWICE_SPACING  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LEFT_NEUMANN   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RIGHT_NEUMANN  = 2'd3;

    localparam logic [COEF_WIDTH-1:0] DIFFUSION_COEF_RST = 31'd65536;
    localparam logic [COEF_WIDTH-1:0] TWICE_SPACING_RST  = 31'd131072;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP_L,
        ST_WAIT_R1,
        ST_EMIT1,
        ST_WAIT_GL,
        ST_DISP_R,
        ST_WAIT_GR,
        ST_DISP_F,
        ST_WAIT_R2,
        ST_EMIT2
    } t_state;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_RND
    } t_mul_phase;

endpackage

FILE: rtl/core/helap_scale.sv
module helap_scale
    import helap_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [COEF_WIDTH-1:0]   i_coef,
    input  logic [SAMPLE_WIDTH+1:0] i_x,
    output logic                    o_done,
    output logic [SAMPLE_WIDTH-1:0] o_result
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int XW   = SW + 2;
    localparam int MW   = SW + 1;
    localparam int LO_W = (MW + 1) / 2;
    localparam int PW   = COEF_WIDTH + MW;
    localparam int RW   = PW + 1 - FRACTION_BITS;

    localparam logic [RW-1:0] POS_LIM = RW'({1'b0, {(SW-1){1'b1}}});
    localparam logic [RW-1:0] NEG_LIM = POS_LIM + RW'(1);
    localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [PW:0]   HALF    = (PW+1)'(1) << (FRACTION_BITS - 1);

    t_mul_phase               r_phase, n_phase;
    logic [COEF_WIDTH-1:0]    r_coef;
    logic [MW-1:0]            r_mag;
    logic                     r_neg;
    logic [PW-1:0]            r_acc;
    logic [SW-1:0]            r_result;
    logic                     r_done;

    logic [XW-1:0]            abs_x;
    logic [LO_W-1:0]          part;
    logic [COEF_WIDTH+LO_W-1:0] pp;
    logic [PW:0]              rnd_sum;
    logic [RW-1:0]            rnd;
    logic [SW-1:0]            sat_val;

    assign abs_x = i_x[XW-1] ? (~i_x + XW'(1)) : i_x;

    // one multiplier, low half of the magnitude then the high half
    assign part = (r_phase == MP_HI) ? LO_W'(r_mag[MW-1:LO_W]) : r_mag[LO_W-1:0];
    assign pp   = r_coef * part;

    // round half away from zero on the magnitude, then clamp by sign
    assign rnd_sum = {1'b0, r_acc} + HALF;
    assign rnd     = rnd_sum[PW:FRACTION_BITS];

    always_comb begin
        if (r_neg) begin
            sat_val = (rnd > NEG_LIM) ? SAT_MIN : (~rnd[SW-1:0] + SW'(1));
        end else begin
            sat_val = (rnd > POS_LIM) ? SAT_MAX : rnd[SW-1:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            MP_IDLE: if (i_start) n_phase = MP_LO;
            MP_LO:   n_phase = MP_HI;
            MP_HI:   n_phase = MP_RND;
            MP_RND:  n_phase = MP_IDLE;
            default: n_phase = MP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == MP_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == MP_IDLE && i_start) begin
            r_coef <= i_coef;
            r_neg  <= i_x[XW-1];
            r_mag  <= abs_x[MW-1:0];
        end
        if (r_phase == MP_LO) begin
            r_acc <= PW'(pp);
        end else if (r_phase == MP_HI) begin
            r_acc <= r_acc + (PW'(pp) << LO_W);
        end
        if (r_phase == MP_RND) begin
            r_result <= sat_val;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/core/heat_equation_laplacian_stencil.sv
// Three-point Laplacian for a streamed 1D heat equation, signed fixed point.
// Input channel (i_in_valid / o_in_ready) takes one interior sample per
// transaction, first to last, with i_is_last marking the final one; the
// boundary fields are read on the first and last sample of a grid.
// Output channel (o_out_valid / i_out_ready) gives one rate per element:
// an element's rate leaves while its right neighbour is processed, and the
// last sample gives two rates (one for a single-sample grid).
// Items are handled one at a time by a sequencer around one shared scaling
// unit: a product is issued and its result is taken after two half-width
// multiplies, a round/clamp step and a registered done flag.
// o_in_ready is high only while the sequencer is idle. A result waits in
// the output register while the receiver stalls; the sequencer stalls in
// turn only when it has a second result ready to load.
// Reset (synchronous, active low) empties the output, starts a new grid and
// restores the configuration defaults. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data with no wait.
module heat_equation_laplacian_stencil
    import helap_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic                     i_is_last,
    input  logic [SAMPLE_WIDTH-1:0]  i_left_boundary,
    input  logic [SAMPLE_WIDTH-1:0]  i_right_boundary,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SAMPLE_WIDTH-1:0]  o_rate,
    output logic                     o_last_of_grid
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int XW = SW + 2;

    function automatic logic [XW-1:0] lap(input logic [SW-1:0] l,
                                          input logic [SW-1:0] m,
                                          input logic [SW-1:0] r);
        logic [XW-1:0] lx, mx, rx;
        lx = {{2{l[SW-1]}}, l};
        mx = {m[SW-1], m, 1'b0};
        rx = {{2{r[SW-1]}}, r};
        return lx - mx + rx;
    endfunction

    function automatic logic [SW-1:0] sat_sum(input logic [SW:0] v);
        if (v[SW] != v[SW-1]) begin
            return v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        return v[SW-1:0];
    endfunction

    // configuration
    logic [COEF_WIDTH-1:0] r_coef, r_tspace;
    logic                  r_left_neu, r_right_neu;

    // sequencer
    t_state        r_state, n_state;
    logic [SW-1:0] r_s, r_lb, r_rb;
    logic          r_last;
    logic [SW-1:0] r_left, n_left;
    logic [SW-1:0] r_right, n_right;
    logic [SW-1:0] r_held, n_held;
    logic [SW-1:0] r_left_nb, n_left_nb;
    logic          r_holding, n_holding;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [SW-1:0] r_rate, n_rate;
    logic          r_out_last, n_out_last;

    logic                  mul_start;
    logic [COEF_WIDTH-1:0] mul_coef;
    logic [XW-1:0]         mul_x;
    logic                  mul_done;
    logic [SW-1:0]         mul_result;
    logic                  accept;
    logic                  out_free;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    helap_scale #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_coef   (mul_coef),
        .i_x      (mul_x),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_held      = r_held;
        n_left_nb   = r_left_nb;
        n_holding   = r_holding;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rate      = r_rate;
        n_out_last  = r_out_last;
        mul_start   = 1'b0;
        mul_coef    = r_coef;
        mul_x       = lap(r_left, r_s, r_right);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DISP_L;
            end
            ST_DISP_L: begin
                priority if (r_holding) begin
                    mul_start = 1'b1;
                    mul_x     = lap(r_left_nb, r_held, r_s);
                    n_state   = ST_WAIT_R1;
                end else if (r_left_neu) begin
                    mul_start = 1'b1;
                    mul_coef  = r_tspace;
                    mul_x     = {{2{r_lb[SW-1]}}, r_lb};
                    n_state   = ST_WAIT_GL;
                end else begin
                    n_left  = r_lb;
                    n_state = ST_DISP_R;
                end
            end
            ST_WAIT_R1: begin
                if (mul_done) n_state = ST_EMIT1;
            end
            ST_EMIT1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rate      = mul_result;
                    n_out_last  = 1'b0;
                    n_left      = r_held;
                    n_state     = ST_DISP_R;
                end
            end
            ST_WAIT_GL: begin
                // left ghost = u - 2dx * slope
                if (mul_done) begin
                    n_left  = sat_sum({r_s[SW-1], r_s} - {mul_result[SW-1], mul_result});
                    n_state = ST_DISP_R;
                end
            end
            ST_DISP_R: begin
                priority if (!r_last) begin
                    n_left_nb = r_left;
                    n_held    = r_s;
                    n_holding = 1'b1;
                    n_state   = ST_IDLE;
                end else if (r_right_neu) begin
                    mul_start = 1'b1;
                    mul_coef  = r_tspace;
                    mul_x     = {{2{r_rb[SW-1]}}, r_rb};
                    n_state   = ST_WAIT_GR;
                end else begin
                    n_right = r_rb;
                    n_state = ST_DISP_F;
                end
            end
            ST_WAIT_GR: begin
                // right ghost = u + 2dx * slope
                if (mul_done) begin
                    n_right = sat_sum({r_s[SW-1], r_s} + {mul_result[SW-1], mul_result});
                    n_state = ST_DISP_F;
                end
            end
            ST_DISP_F: begin
                mul_start = 1'b1;
                n_state   = ST_WAIT_R2;
            end
            ST_WAIT_R2: begin
                if (mul_done) n_state = ST_EMIT2;
            end
            ST_EMIT2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rate      = mul_result;
                    n_out_last  = 1'b1;
                    n_holding   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_holding   <= 1'b0;
            r_out_valid <= 1'b0;
            r_coef      <= DIFFUSION_COEF_RST;
            r_tspace    <= TWICE_SPACING_RST;
            r_left_neu  <= 1'b0;
            r_right_neu <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_holding   <= n_holding;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIFFUSION_COEF: r_coef      <= i_cfg_data;
                    CFG_TWICE_SPACING:  r_tspace    <= i_cfg_data;
                    CFG_LEFT_NEUMANN:   r_left_neu  <= i_cfg_data[0];
                    CFG_RIGHT_NEUMANN:  r_right_neu <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s    <= i_sample;
            r_last <= i_is_last;
            r_lb   <= i_left_boundary;
            r_rb   <= i_right_boundary;
        end
        r_left     <= n_left;
        r_right    <= n_right;
        r_held     <= n_held;
        r_left_nb  <= n_left_nb;
        r_rate     <= n_rate;
        r_out_last <= n_out_last;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_rate         = r_rate;
    assign o_last_of_grid = r_out_last;

endmodule
